// ----- rtl/tsbm_pkg.sv -----
package tsbm_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int CSTAGES       = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int DIV_STEPS     = 31;
    localparam int NORM_STEPS    = 6;

    localparam logic [1:0] REG_A_X = 2'd0;
    localparam logic [1:0] REG_A_Y = 2'd1;
    localparam logic [1:0] REG_B_X = 2'd2;
    localparam logic [1:0] REG_B_Y = 2'd3;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic        [31:0] z;
    } cord_t;

    typedef struct packed {
        logic [65:0] den;
        logic [72:0] rem;
        logic [32:0] num;
        logic [30:0] quo;
        logic        sat;
        logic        neg;
    } div_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [32:0] ax;
        logic        [32:0] ay;
    } diff_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] t [0:TAB_LEN-1];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction

endpackage

// ----- rtl/two_station_bearing_model.sv -----
// The pipeline has front registers, normalization steps, then the CORDIC stages and 31 divider steps side by side.
// Throughput: one beat per cycle while the output is not stalled; the CORDIC and divider cell rows advance together.
// The whole pipeline holds while the output beat is stalled.
// Reset clears the station registers to 0 and the pipeline valid bits.
module two_station_bearing_model import tsbm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               stall_in,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    output logic               valid_out,
    input  logic               stall_out,
    output logic [15:0]        bearing_a,
    output logic [15:0]        bearing_b,
    output logic signed [31:0] slope_a_wrt_x,
    output logic signed [31:0] slope_a_wrt_y,
    output logic signed [31:0] slope_b_wrt_x,
    output logic signed [31:0] slope_b_wrt_y,
    output logic [1:0]         zero_range,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int LAT = 3 + NORM_STEPS + ((CSTAGES > DIV_STEPS) ? CSTAGES : DIV_STEPS);

    logic [31:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [LAT-1:0] vld_reg;
    logic en;
    logic [31:0] sxa, sya, sxb, syb;

    assign cfg_ready = 1'b1;
    assign en        = !(valid_out && stall_out);
    assign stall_in  = !en;
    assign valid_out = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg  <= '0;
            ay_reg  <= '0;
            bx_reg  <= '0;
            by_reg  <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_A_X: ax_reg <= cfg_data;
                    REG_A_Y: ay_reg <= cfg_data;
                    REG_B_X: bx_reg <= cfg_data;
                    REG_B_Y: by_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], valid_in};
        end
    end

    tsbm_station u_a (
        .clk(clk), .en(en), .tx(target_x), .ty(target_y),
        .sx(ax_reg), .sy(ay_reg), .bearing(bearing_a),
        .slope_x(sxa), .slope_y(sya), .zero(zero_range[0])
    );

    tsbm_station u_b (
        .clk(clk), .en(en), .tx(target_x), .ty(target_y),
        .sx(bx_reg), .sy(by_reg), .bearing(bearing_b),
        .slope_x(sxb), .slope_y(syb), .zero(zero_range[1])
    );

    assign slope_a_wrt_x = signed'(sxa);
    assign slope_a_wrt_y = signed'(sya);
    assign slope_b_wrt_x = signed'(sxb);
    assign slope_b_wrt_y = signed'(syb);
endmodule

// ----- rtl/tsbm_cordic_cell.sv -----
module tsbm_cordic_cell import tsbm_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic  clk,
    input  logic  en,
    input  cord_t a,
    output cord_t q
);
    cord_t q_reg;
    cord_t q_next;
    logic signed [34:0] xs;
    logic signed [34:0] ys;

    always_comb
    begin
        xs = a.x >>> STAGE;
        ys = a.y >>> STAGE;
        if (!a.y[34])
        begin
            q_next.x = a.x + ys;
            q_next.y = a.y - xs;
            q_next.z = a.z + atan_entry(STAGE);
        end
        else
        begin
            q_next.x = a.x - ys;
            q_next.y = a.y + xs;
            q_next.z = a.z - atan_entry(STAGE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

// ----- rtl/tsbm_div_cell.sv -----
module tsbm_div_cell import tsbm_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic clk,
    input  logic en,
    input  div_t a,
    output div_t q
);
    div_t q_reg;
    div_t q_next;
    logic [73:0] trial;
    logic [72:0] sh;

    always_comb
    begin
        q_next = a;
        sh = a.rem << 1;
        trial = {1'b0, sh} - {8'd0, a.den};
        if (!trial[73])
        begin
            q_next.rem = trial[72:0];
            q_next.quo = a.quo | (31'd1 << (30 - STEP));
        end
        else
        begin
            q_next.rem = sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

// ----- rtl/tsbm_station.sv -----
module tsbm_station import tsbm_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] tx,
    input  logic signed [31:0] ty,
    input  logic signed [31:0] sx,
    input  logic signed [31:0] sy,
    output logic [15:0]        bearing,
    output logic [31:0]        slope_x,
    output logic [31:0]        slope_y,
    output logic               zero
);
    localparam int LAT = 3 + NORM_STEPS + ((CSTAGES > DIV_STEPS) ? CSTAGES : DIV_STEPS);

    diff_t d_reg;
    logic [65:0] qx_reg, qy_reg;
    diff_t d2_reg;

    logic signed [34:0] nx_reg [0:NORM_STEPS];
    logic signed [34:0] ny_reg [0:NORM_STEPS];
    logic        [31:0] nz_reg [0:NORM_STEPS];
    cord_t cc [0:CSTAGES];

    div_t dvx [0:DIV_STEPS];
    div_t dvy [0:DIV_STEPS];

    logic        zero_sh_reg [0:LAT-1];

    logic [32:0] ax_n, ay_n;

    always_comb
    begin
        ax_n = 33'(signed'({tx[31], tx}) - signed'({sx[31], sx}));
        ay_n = 33'(signed'({ty[31], ty}) - signed'({sy[31], sy}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg.dx <= signed'(ax_n);
            d_reg.dy <= signed'(ay_n);
            d_reg.ax <= ax_n[32] ? 33'(-ax_n) : ax_n;
            d_reg.ay <= ay_n[32] ? 33'(-ay_n) : ay_n;
            qx_reg   <= 66'(d_reg.ax) * 66'(d_reg.ax);
            qy_reg   <= 66'(d_reg.ay) * 66'(d_reg.ay);
            d2_reg   <= d_reg;
        end
    end

    // stage 0 of normalization: fold into right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d2_reg.dx < 0)
            begin
                nx_reg[0] <= 35'(-d2_reg.dx);
                ny_reg[0] <= 35'(-d2_reg.dy);
                nz_reg[0] <= 32'h80000000;
            end
            else
            begin
                nx_reg[0] <= 35'(d2_reg.dx);
                ny_reg[0] <= 35'(d2_reg.dy);
                nz_reg[0] <= 32'd0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NORM_STEPS; g++) begin : g_norm
            localparam int SH = 32 >> g;
            logic [33:0] mx, my, mm;
            always_comb
            begin
                mx = nx_reg[g][33:0];
                my = ny_reg[g][34] ? 34'(-ny_reg[g]) : ny_reg[g][33:0];
                mm = (mx > my) ? mx : my;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nz_reg[g+1] <= nz_reg[g];
                    if (mm != 34'd0 && (mm << SH) < 34'h80000000 * 2 && (mm >> (32 - SH)) == 34'd0
                        && (mm << SH) <= 34'h0FFFFFFFF)
                    begin
                        nx_reg[g+1] <= nx_reg[g] <<< SH;
                        ny_reg[g+1] <= ny_reg[g] <<< SH;
                    end
                    else
                    begin
                        nx_reg[g+1] <= nx_reg[g];
                        ny_reg[g+1] <= ny_reg[g];
                    end
                end
            end
        end
    endgenerate

    assign cc[0].x = nx_reg[NORM_STEPS];
    assign cc[0].y = ny_reg[NORM_STEPS];
    assign cc[0].z = nz_reg[NORM_STEPS];

    generate
        for (g = 0; g < CSTAGES; g++) begin : g_cord
            tsbm_cordic_cell #(.STAGE(g)) u_cell (
                .clk(clk), .en(en), .a(cc[g]), .q(cc[g+1])
            );
        end
    endgenerate

    // divider delay line aligns entry with CORDIC entry
    diff_t dd_reg [0:NORM_STEPS];
    logic [65:0] ddn_reg [0:NORM_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= d2_reg;
            ddn_reg[0] <= qx_reg + qy_reg;
        end
    end

    generate
        for (g = 0; g < NORM_STEPS; g++) begin : g_dd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dd_reg[g+1]  <= dd_reg[g];
                    ddn_reg[g+1] <= ddn_reg[g];
                end
            end
        end
    endgenerate

    logic [72:0] numx_w, numy_w;
    logic        satx0, saty0;
    always_comb
    begin
        numx_w = {dd_reg[NORM_STEPS].ay, 40'd0};
        numy_w = {dd_reg[NORM_STEPS].ax, 40'd0};
        satx0 = (numx_w >> 31) >= 73'(ddn_reg[NORM_STEPS]);
        saty0 = (numy_w >> 31) >= 73'(ddn_reg[NORM_STEPS]);
    end

    assign dvx[0].den = ddn_reg[NORM_STEPS];
    assign dvx[0].rem = 73'(numx_w >> 31);
    assign dvx[0].num = dd_reg[NORM_STEPS].ay;
    assign dvx[0].quo = '0;
    assign dvx[0].sat = satx0;
    assign dvx[0].neg = dd_reg[NORM_STEPS].dy > 0;
    assign dvy[0].den = ddn_reg[NORM_STEPS];
    assign dvy[0].rem = 73'(numy_w >> 31);
    assign dvy[0].num = dd_reg[NORM_STEPS].ax;
    assign dvy[0].quo = '0;
    assign dvy[0].sat = saty0;
    assign dvy[0].neg = dd_reg[NORM_STEPS].dx < 0;

    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            div_t ix, iy;
            always_comb
            begin
                ix = dvx[g];
                iy = dvy[g];
                ix.rem = (g == 0) ? dvx[g].rem : dvx[g].rem;
                iy.rem = (g == 0) ? dvy[g].rem : dvy[g].rem;
            end
            tsbm_div_cell #(.STEP(g)) u_dx (.clk(clk), .en(en), .a(ix), .q(dvx[g+1]));
            tsbm_div_cell #(.STEP(g)) u_dy (.clk(clk), .en(en), .a(iy), .q(dvy[g+1]));
        end
    endgenerate

    // remainder seed: remainder of numerator high part modulo denominator
    // is handled by saturation; when not saturated high part < den already.

    localparam int CL = (CSTAGES > DIV_STEPS) ? CSTAGES : DIV_STEPS;
    localparam int CPAD = CL - CSTAGES;
    localparam int DPAD = CL - DIV_STEPS;

    cord_t cdel [0:CPAD];
    div_t xdel [0:DPAD];
    div_t ydel [0:DPAD];
    assign cdel[0] = cc[CSTAGES];
    assign xdel[0] = dvx[DIV_STEPS];
    assign ydel[0] = dvy[DIV_STEPS];

    generate
        for (g = 0; g < CPAD; g++) begin : g_cp
            cord_t r;
            always_ff @(posedge clk)
            begin
                if (en)
                    r <= cdel[g];
            end
            assign cdel[g+1] = r;
        end
        for (g = 0; g < DPAD; g++) begin : g_dp
            div_t rx, ry;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx <= xdel[g];
                    ry <= ydel[g];
                end
            end
            assign xdel[g+1] = rx;
            assign ydel[g+1] = ry;
        end
    endgenerate

    logic [31:0] zr;
    logic [31:0] mxq, myq;

    always_comb
    begin
        zr = cdel[CPAD].z + (32'd1 << (31 - ANGLE_BITS));
        mxq = {1'b0, xdel[DPAD].quo};
        myq = {1'b0, ydel[DPAD].quo};
        if (zero_sh_reg[LAT-1])
        begin
            bearing = '0;
            slope_x = '0;
            slope_y = '0;
        end
        else
        begin
            bearing = 16'(zr >> (32 - ANGLE_BITS));
            if (xdel[DPAD].sat)
                slope_x = xdel[DPAD].neg ? 32'h80000000 : 32'h7FFFFFFF;
            else
                slope_x = xdel[DPAD].neg ? 32'(-mxq) : mxq;
            if (ydel[DPAD].sat)
                slope_y = ydel[DPAD].neg ? 32'h80000000 : 32'h7FFFFFFF;
            else
                slope_y = ydel[DPAD].neg ? 32'(-myq) : myq;
        end
        zero = zero_sh_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_sh_reg[0] <= (ax_n == 33'd0) && (ay_n == 33'd0);
            for (int k = 1; k < LAT; k++)
                zero_sh_reg[k] <= zero_sh_reg[k-1];
        end
    end
endmodule

// ----- rtl/tsbm_checker.sv -----
module tsbm_checker import tsbm_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        stall_in,
    input logic        valid_out,
    input logic        stall_out,
    input logic [15:0] bearing_a,
    input logic [1:0]  zero_range,
    input logic [31:0] slope_a_wrt_x
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && stall_out |=> valid_out && $stable(bearing_a))
        else $error("stalled beat changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall_in |-> valid_out && stall_out)
        else $error("input stalled without output stall");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && zero_range[0] |-> bearing_a == 16'd0 && slope_a_wrt_x == 32'd0)
        else $error("zero range fields not cleared");
endmodule

bind two_station_bearing_model tsbm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .stall_in(stall_in),
    .valid_out(valid_out), .stall_out(stall_out), .bearing_a(bearing_a),
    .zero_range(zero_range), .slope_a_wrt_x(slope_a_wrt_x)
);
